### sv/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants for the first-fit slot allocator
// Holds the field widths, the slot table entry layout, the memory request
// bundle, the result record and the scan state encoding.
// ----------------------------------------------------------------------------
package ffa_pkg;

    // Table size and field widths
    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int TAG_W     = 16;
    localparam int STEP_W    = 10;
    localparam int SIZE_W    = 40;

    // One slot table entry: peak element count and last-read step
    typedef struct packed {
        logic [SIZE_W-1:0] peak_size;
        logic [STEP_W-1:0] free_after;
    } slot_entry_t;

    // Access bundle from the scan engine to the slot memory
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        slot_entry_t       wr_data;
    } mem_req_t;

    // One allocation result
    typedef struct packed {
        logic [TAG_W-1:0]  tag_out;
        logic [SLOT_W-1:0] slot_index;
        logic              opened_new;
        logic              overflow;
        logic [SIZE_W-1:0] slot_size;
        logic [CNT_W-1:0]  slots_in_use;
    } result_t;

    // Scan engine states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } scan_state_t;

endpackage

### sv/ffa_slot_mem.sv
// ----------------------------------------------------------------------------
// ffa_slot_mem: slot table storage
// Single synchronous memory holding one entry per slot, with one write port
// and one read port whose data is registered.
// ----------------------------------------------------------------------------
module ffa_slot_mem
    import ffa_pkg::*;
(
    input  logic        clk,
    input  mem_req_t    req,
    output slot_entry_t rd_data
);

    slot_entry_t mem [MAX_SLOTS];
    slot_entry_t rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/ffa_scan.sv
// ----------------------------------------------------------------------------
// ffa_scan: first-fit scan engine
// Walks the opened slots in order, one memory read per cycle, and stops at
// the first slot whose last-read step lies below the new write step. It then
// reuses that slot or opens a new one and writes back, or flags overflow.
// ----------------------------------------------------------------------------
module ffa_scan
    import ffa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Incoming interval
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_start,
    input  logic [TAG_W-1:0]  in_tag,
    input  logic [STEP_W-1:0] in_wstep,
    input  logic [STEP_W-1:0] in_rstep,
    input  logic [SIZE_W-1:0] in_elems,
    // Slot memory
    output mem_req_t          mem_req,
    input  slot_entry_t       mem_rdata,
    // Result
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    scan_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pend_idx_reg, pend_idx_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] pick_reg, pick_next;
    logic [SIZE_W-1:0] peak_reg, peak_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [STEP_W-1:0] wstep_reg, wstep_next;
    logic [STEP_W-1:0] rstep_reg, rstep_next;
    logic [SIZE_W-1:0] elems_reg, elems_next;

    logic              accept;
    logic              hit;
    logic              more;
    logic              miss_end;
    logic              ovf;
    logic              opened;
    logic              commit;
    logic [SIZE_W-1:0] new_peak;
    logic [SLOT_W-1:0] chosen;

    // Scan conditions: the entry read last cycle qualifies, entries remain
    assign accept   = in_valid && in_ready;
    assign hit      = pend_reg && (mem_rdata.free_after < wstep_reg);
    assign more     = rd_idx_reg < count_reg;
    assign miss_end = !pend_reg && !more;

    // Decision once the scan is over
    assign ovf      = !found_reg && (count_reg == CNT_W'(MAX_SLOTS));
    assign opened   = !found_reg && !ovf;
    assign new_peak = (found_reg && (peak_reg > elems_reg)) ? peak_reg : elems_reg;
    assign chosen   = found_reg ? pick_reg :
                      (opened ? count_reg[SLOT_W-1:0] : '0);
    assign commit   = (state_reg == ST_DONE) && res_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit || miss_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        pick_next     = pick_reg;
        peak_next     = peak_reg;
        tag_next      = tag_reg;
        wstep_next    = wstep_reg;
        rstep_next    = rstep_reg;
        elems_next    = elems_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_req       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    if (in_start)
                    begin
                        count_next = '0;
                    end
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    tag_next    = in_tag;
                    wstep_next  = in_wstep;
                    rstep_next  = in_rstep;
                    elems_next  = in_elems;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    pick_next  = pend_idx_reg;
                    peak_next  = mem_rdata.peak_size;
                    pend_next  = 1'b0;
                end
                else if (more)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = rd_idx_reg[SLOT_W-1:0];
                    pend_next       = 1'b1;
                    pend_idx_next   = rd_idx_reg[SLOT_W-1:0];
                    rd_idx_next     = rd_idx_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (commit)
                begin
                    mem_req.wr_en              = !ovf;
                    mem_req.wr_addr            = chosen;
                    mem_req.wr_data.peak_size  = new_peak;
                    mem_req.wr_data.free_after = rstep_reg;
                    if (opened)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Result record
    always_comb
    begin
        res.tag_out      = tag_reg;
        res.slot_index   = chosen;
        res.opened_new   = opened;
        res.overflow     = ovf;
        res.slot_size    = ovf ? '0 : new_peak;
        res.slots_in_use = opened ? count_reg + 1'b1 : count_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
        end
    end

    // Item and scan payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        pick_reg     <= pick_next;
        peak_reg     <= peak_next;
        tag_reg      <= tag_next;
        wstep_reg    <= wstep_next;
        rstep_reg    <= rstep_next;
        elems_reg    <= elems_next;
    end

    // The open count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SLOTS))
        else $error("open slot count exceeds table size");

    // A read in flight only exists during the scan
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("pending read outside the scan");

    // Write-back only touches opened slots or the next one
    a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> ({1'b0, mem_req.wr_addr} <= count_reg))
        else $error("write-back beyond opened slots");

    // Overflow only with a full table, and then nothing is written
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.overflow) |->
            ((count_reg == CNT_W'(MAX_SLOTS)) && !mem_req.wr_en))
        else $error("overflow with room left or with a write");

    // A completed result frees the engine for the next interval
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (state_reg == ST_IDLE) && (count_reg == $past(res.slots_in_use)))
        else $error("engine did not return to idle after a result");

endmodule

### sv/first_fit_buffer_slot_allocator_core.sv
// One buffer lifetime interval enters per transfer on the slave stream and
// produces exactly one result transfer on the master stream. At most 64
// slots are open at once. The slot table sits in a single memory with one
// read port, and the scan reads one entry per cycle before a single
// write-back. The result sits in an output register, so the next interval
// is taken while an earlier result still waits on the master side.
// ----------------------------------------------------------------------------
// first_fit_buffer_slot_allocator_core: first-fit buffer slot allocator
// Places each interval into the lowest slot whose last read precedes the new
// first write, opens a new slot otherwise, and flags overflow on a full table.
// ----------------------------------------------------------------------------
module first_fit_buffer_slot_allocator_core
    import ffa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // buffer_tag, write_step, read_step, element_count
    input  logic [0:0]  s_tuser,   // start_program
    // Master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // tag_out, slot_index, slot_size, slots_in_use
    output logic [1:0]  m_tuser    // opened_new, overflow
);

    mem_req_t    mem_req;
    slot_entry_t mem_rdata;
    logic        res_valid;
    logic        res_ready;
    result_t     res;

    logic        m_valid_reg, m_valid_next;
    result_t     out_reg, out_next;

    // Slot table storage
    ffa_slot_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rdata)
    );

    // First-fit scan engine
    ffa_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_start  (s_tuser[0]),
        .in_tag    (s_tdata[15:0]),
        .in_wstep  (s_tdata[25:16]),
        .in_rstep  (s_tdata[35:26]),
        .in_elems  (s_tdata[75:36]),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register takes a result whenever it is empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_ready)
        begin
            m_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Master stream packing
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_reg.slots_in_use, out_reg.slot_size,
                       out_reg.slot_index, out_reg.tag_out};
    assign m_tuser  = {out_reg.overflow, out_reg.opened_new};

    // An overflow result never names a slot or a size
    a_ovf_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |->
            (!m_tuser[0] && (m_tdata[21:16] == '0) && (m_tdata[61:22] == '0)))
        else $error("overflow result carries a slot");

    // A newly opened slot is always the last one in use
    a_open_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |->
            ({1'b0, m_tdata[21:16]} + 7'd1 == m_tdata[68:62]))
        else $error("opened slot is not the newest slot");

    // A result only enters the output register when there is room for it
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |=> $stable(out_reg))
        else $error("held result overwritten");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the first-fit buffer slot allocator
// Streams mostly sorted buffer lifetime intervals into the allocator, predicts each
// slot grant from a private copy of the slot table, and compares every field
// of every result. Both streams idle at random, and the result side holds off
// once for a long stretch so that the allocator fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
    import ffa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 550;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_AT = 150;
    localparam int HOLD_CYCLES = 600;

    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
    localparam logic [STEP_W-1:0] STEP_MAX = '1;
    localparam logic [TAG_W-1:0]  TAG_MAX  = '1;

    // Predicts slot grants and holds the grants still owed by the allocator.
    class slot_grant_tracker;
        logic [STEP_W-1:0] free_after [MAX_SLOTS];
        logic [SIZE_W-1:0] peak_size [MAX_SLOTS];
        int unsigned open_cnt;
        result_t owed_grants[$];
        int errors;
        int n_items, n_reused, n_opened, n_overflow, n_starts;

        function new();
            open_cnt = 0;
            errors = 0;
            n_items = 0;
            n_reused = 0;
            n_opened = 0;
            n_overflow = 0;
            n_starts = 0;
        endfunction

        // Works out the grant for one accepted interval and queues it.
        function void note_interval(input logic st, input logic [TAG_W-1:0] tag,
                                    input logic [STEP_W-1:0] wstep,
                                    input logic [STEP_W-1:0] rstep,
                                    input logic [SIZE_W-1:0] elems);
            result_t g;
            int pick;
            bit found;
            n_items++;
            if (st)
            begin
                open_cnt = 0;
                n_starts++;
            end
            found = 1'b0;
            pick = 0;
            for (int s = 0; s < open_cnt; s++)
            begin
                if (!found && free_after[s] < wstep)
                begin
                    pick = s;
                    found = 1'b1;
                end
            end
            g = '0;
            g.tag_out = tag;
            if (found)
            begin
                free_after[pick] = rstep;
                if (elems > peak_size[pick])
                    peak_size[pick] = elems;
                g.slot_index = pick[SLOT_W-1:0];
                g.slot_size = peak_size[pick];
                n_reused++;
            end
            else if (open_cnt < MAX_SLOTS)
            begin
                free_after[open_cnt] = rstep;
                peak_size[open_cnt] = elems;
                g.slot_index = open_cnt[SLOT_W-1:0];
                g.slot_size = elems;
                g.opened_new = 1'b1;
                open_cnt++;
                n_opened++;
            end
            else
            begin
                g.overflow = 1'b1;
                n_overflow++;
            end
            g.slots_in_use = open_cnt[CNT_W-1:0];
            owed_grants = {owed_grants, g};
        endfunction

        // Compares one result transfer with the oldest owed grant.
        function void check_grant(input logic [71:0] d, input logic [1:0] u);
            result_t g;
            if (owed_grants.size() == 0)
            begin
                $error("result with no interval waiting: tdata %h tuser %b", d, u);
                errors++;
                return;
            end
            g = owed_grants.pop_front();
            if (d[15:0] !== g.tag_out)
            begin
                $error("tag_out: expected %h, actual %h", g.tag_out, d[15:0]);
                errors++;
            end
            if (d[21:16] !== g.slot_index)
            begin
                $error("slot_index: expected %0d, actual %0d", g.slot_index, d[21:16]);
                errors++;
            end
            if (d[61:22] !== g.slot_size)
            begin
                $error("slot_size: expected %h, actual %h", g.slot_size, d[61:22]);
                errors++;
            end
            if (d[68:62] !== g.slots_in_use)
            begin
                $error("slots_in_use: expected %0d, actual %0d", g.slots_in_use, d[68:62]);
                errors++;
            end
            if (d[71:69] !== 3'b000)
            begin
                $error("tdata pad: expected 0, actual %b", d[71:69]);
                errors++;
            end
            if (u[0] !== g.opened_new)
            begin
                $error("opened_new: expected %b, actual %b", g.opened_new, u[0]);
                errors++;
            end
            if (u[1] !== g.overflow)
            begin
                $error("overflow: expected %b, actual %b", g.overflow, u[1]);
                errors++;
            end
        endfunction

        function int pending();
            return owed_grants.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;   // buffer_tag, write_step, read_step, element_count
    logic [0:0]  s_tuser = '0;   // start_program
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // tag_out, slot_index, slot_size, slots_in_use
    logic [1:0]  m_tuser;        // opened_new, overflow

    slot_grant_tracker grants = new();
    bit steady = 1'b0;
    int cycles = 0;
    int results_seen = 0;

    first_fit_buffer_slot_allocator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Run-away guard.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_elems();
        logic [SIZE_W-1:0] e;
        int r;
        r = $urandom_range(0, 9);
        e[31:0] = $urandom;
        e[39:32] = 8'($urandom_range(0, 255));
        if (r == 0)
            e = '0;
        else if (r == 1)
            e = SIZE_MAX;
        else if (r < 5)
            e = SIZE_W'($urandom_range(0, 4096));
        return e;
    endfunction

    // Offers one interval and waits for its transfer.
    task automatic push_interval(input logic st, input logic [TAG_W-1:0] tag,
                                 input logic [STEP_W-1:0] wstep,
                                 input logic [STEP_W-1:0] rstep,
                                 input logic [SIZE_W-1:0] elems);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, elems, rstep, wstep, tag};
        s_tuser <= st;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        grants.note_interval(st, tag, wstep, rstep, elems);
    endtask

    // A program of sorted intervals with random lifetimes.
    task automatic push_program(input int len);
        logic [STEP_W-1:0] w;
        logic [STEP_W-1:0] r;
        int nxt;
        w = STEP_W'($urandom_range(0, 20));
        for (int i = 0; i < len; i++)
        begin
            nxt = w + $urandom_range(0, 30);
            w = (nxt > STEP_MAX) ? STEP_MAX : nxt[STEP_W-1:0];
            if ($urandom_range(0, 9) == 0)
                r = (w == 0) ? '0 : STEP_W'($urandom_range(0, w - 1));
            else
            begin
                nxt = w + $urandom_range(0, 200);
                r = (nxt > STEP_MAX) ? STEP_MAX : nxt[STEP_W-1:0];
            end
            push_interval(i == 0, TAG_W'($urandom), w, r, pick_elems());
        end
    endtask

    // A program whose buffers all live to the end, so the table fills up.
    task automatic push_filling_program(input int len);
        logic [STEP_W-1:0] w;
        w = '0;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 1) == 1 && w < STEP_MAX - 1)
                w = w + 1'b1;
            push_interval(i == 0, TAG_W'($urandom), w,
                          ($urandom_range(0, 7) == 0) ? STEP_MAX - 1'b1 : STEP_MAX,
                          pick_elems());
        end
    endtask

    // Unsorted noise, with the odd start flag.
    task automatic push_noise(input int len);
        for (int i = 0; i < len; i++)
            push_interval($urandom_range(0, 7) == 0, TAG_W'($urandom), STEP_W'($urandom),
                          STEP_W'($urandom), pick_elems());
    endtask

    // Result side: random stalls, plus one long hold-off counted here.
    initial
    begin
        int idle_left;
        int hold_left;
        bit held;
        idle_left = 0;
        hold_left = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                grants.check_grant(m_tdata, m_tuser);
                results_seen++;
                idle_left = pick_gap();
            end
            if (!held && results_seen == HOLD_AT)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int kind;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, then zero and full-scale fields.
        push_interval(1'b1, '0, '0, '0, '0);
        // A slot freed at the same step as the new write stays busy.
        push_interval(1'b0, TAG_MAX, '0, 10'd5, SIZE_MAX);
        // Slot 0 was last read at step 0, so it is reused at step 1.
        push_interval(1'b0, 16'h1234, 10'd1, STEP_MAX, 40'd5);
        // Equal steps once more, with a read step below the write step.
        push_interval(1'b0, 16'h5678, 10'd5, 10'd3, 40'd77);
        // Reuse without growing the peak size.
        push_interval(1'b0, 16'h9abc, 10'd6, 10'd6, 40'd1);
        push_interval(1'b0, 16'hdef0, 10'd6, 10'd900, SIZE_MAX - 1'b1);
        push_interval(1'b0, 16'h0f0f, STEP_MAX, '0, 40'h00_ffff_ffff);
        push_interval(1'b0, 16'hf0f0, STEP_MAX, STEP_MAX, 40'h55_5555_5555);
        // Start flag in mid-program clears the table before placing.
        push_interval(1'b1, 16'haaaa, STEP_MAX, STEP_MAX, 40'haa_aaaa_aaaa);
        push_interval(1'b0, 16'h5555, '0, 10'h2aa, 40'd3);
        push_interval(1'b1, 16'h0001, 10'h155, 10'h2aa, 40'h80_0000_0000);

        // Table full: more live buffers than slots.
        push_filling_program(MAX_SLOTS + 4);

        while (grants.n_items < ITEM_TARGET)
        begin
            steady = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 2)
                push_filling_program(MAX_SLOTS + $urandom_range(1, 8));
            else if (kind < 8)
                push_program($urandom_range(1, 40));
            else
                push_noise($urandom_range(1, 10));
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        while (grants.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d intervals in %0d programs, %0d results checked",
                 grants.n_items, grants.n_starts, results_seen);
        $display("tb: %0d slots opened, %0d reused, %0d overflows, %0d mismatches",
                 grants.n_opened, grants.n_reused, grants.n_overflow, grants.errors);
        if (grants.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### files.f
sv/ffa_pkg.sv
sv/ffa_slot_mem.sv
sv/ffa_scan.sv
sv/first_fit_buffer_slot_allocator_core.sv
tb/sv/tb.sv
